>>> rtl/core/crs_pkg.sv
// Shared types and codes for the code point range set.
`default_nettype none
package crs_pkg;

    localparam int COUNT_W  = 7;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_NEGATE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CAPACITY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRY,
        S_CHECK,
        S_WET,
        S_ROT,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/crs_cell.sv
// One cell of the range queue: holds one range, shifts toward the head or loads.
`default_nettype none
module crs_cell #(
    parameter int CODE_BITS = 21
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_shift,
    input  wire logic                 i_load,
    input  wire logic [CODE_BITS-1:0] i_next_lo,
    input  wire logic [CODE_BITS-1:0] i_next_hi,
    input  wire logic [CODE_BITS-1:0] i_bus_lo,
    input  wire logic [CODE_BITS-1:0] i_bus_hi,
    output logic      [CODE_BITS-1:0] o_lo,
    output logic      [CODE_BITS-1:0] o_hi
);
    logic [CODE_BITS-1:0] r_lo, r_hi;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lo <= i_bus_lo;
            r_hi <= i_bus_hi;
        end else if (i_shift) begin
            r_lo <= i_next_lo;
            r_hi <= i_next_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;
endmodule
`default_nettype wire

>>> rtl/core/code_point_range_set.sv
// Top level of the code point range set: cell queue, sequencer and output register.
// The set lives in a row of MAX_RANGES cells used as a queue, head at cell 0,
// ranges sorted ascending. A walk moves one entry per cycle unless a pending
// second range or a full output register holds it: the head cell is popped,
// run through a small merge/split/complement step and the result pushed at
// the tail. Insert, remove and negate take two walks (an insert or remove
// with a bad range takes none): a counting walk that rotates the queue
// unchanged to find the new range count (so an over-capacity change leaves
// the table untouched), then a rewrite walk that, whenever a step yields two
// ranges (a split, or a new range placed ahead of a stored one), pushes the
// second from a pending register before popping on. Read-out gives one word
// per range, pacing with i_ready; an empty set reads as a single response
// word. One input word is in flight at a time; the input is taken again once
// the result word is loaded into the output register. The user must write
// configuration (code_max) only while idle; the block does not enforce it.
`default_nettype none
module code_point_range_set
    import crs_pkg::*;
#(
    parameter int MAX_RANGES = 32,
    parameter int CODE_BITS  = 21
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config
    input  wire logic                 i_code_max_we,
    input  wire logic [CODE_BITS-1:0] i_code_max,
    // input channel
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [ACTION_W-1:0]  i_action,
    input  wire logic [CODE_BITS-1:0] i_low_code,
    input  wire logic [CODE_BITS-1:0] i_high_code,
    // output channel
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_member,
    output logic [STATUS_W-1:0]       o_status,
    output logic [CODE_BITS-1:0]      o_range_low,
    output logic [CODE_BITS-1:0]      o_range_high,
    output logic                      o_set_empty,
    output logic [COUNT_W-1:0]        o_range_count,
    output logic                      o_last
);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int NW = $clog2(MAX_RANGES + 2);
    localparam int IW = (MAX_RANGES > 2) ? $clog2(MAX_RANGES) : 1;
    localparam int XB = CODE_BITS + 1;

    t_state r_state, n_state;

    logic [CODE_BITS-1:0] r_code_max;
    logic [ACTION_W-1:0]  r_act;
    logic [CODE_BITS-1:0] r_lo, r_hi;
    logic [CW-1:0]        r_count, r_occ, r_idx;
    logic [NW-1:0]        r_new;
    logic [STATUS_W-1:0]  r_status;
    logic                 r_member;

    // step state
    logic [CODE_BITS-1:0] r_alo, r_ahi;
    logic                 r_placed, r_brk;
    logic [XB-1:0]        r_b;
    logic                 r_pend;
    logic [CODE_BITS-1:0] r_pend_lo, r_pend_hi;

    // output register
    logic                 r_ovalid, r_omember, r_olast;
    logic [STATUS_W-1:0]  r_ostatus;
    logic [CODE_BITS-1:0] r_olo, r_ohi;
    logic [CW-1:0]        r_ocount;

    // cell row
    logic [CODE_BITS-1:0] w_lo [MAX_RANGES];
    logic [CODE_BITS-1:0] w_hi [MAX_RANGES];
    logic                 pop, push;
    logic [CODE_BITS-1:0] bus_lo, bus_hi;
    logic [IW-1:0]        wr_idx;
    logic [CW-1:0]        wr_full;

    assign wr_full = pop ? (r_occ - CW'(1)) : r_occ;
    assign wr_idx  = wr_full[IW-1:0];

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        logic [CODE_BITS-1:0] nx_lo, nx_hi;
        if (g == MAX_RANGES - 1) begin : g_tail
            assign nx_lo = w_lo[g];
            assign nx_hi = w_hi[g];
        end else begin : g_mid
            assign nx_lo = w_lo[g+1];
            assign nx_hi = w_hi[g+1];
        end
        crs_cell #(.CODE_BITS(CODE_BITS)) u_cell (
            .i_clk     (i_clk),
            .i_shift   (pop),
            .i_load    (push && (wr_idx == IW'(g))),
            .i_next_lo (nx_lo),
            .i_next_hi (nx_hi),
            .i_bus_lo  (bus_lo),
            .i_bus_hi  (bus_hi),
            .o_lo      (w_lo[g]),
            .o_hi      (w_hi[g])
        );
    end

    // ---- step unit: one head entry in, up to two ranges out ----
    logic [CODE_BITS-1:0] h_lo, h_hi;
    logic                 o0v, o1v;
    logic [CODE_BITS-1:0] o0_lo, o0_hi, o1_lo, o1_hi;
    logic [CODE_BITS-1:0] s_alo, s_ahi;
    logic                 s_placed, s_brk;
    logic [XB-1:0]        s_b;
    logic                 fin_v;
    logic [CODE_BITS-1:0] fin_lo, fin_hi;

    assign h_lo = w_lo[0];
    assign h_hi = w_hi[0];

    always_comb begin
        o0v = 1'b0;  o1v = 1'b0;
        o0_lo = h_lo; o0_hi = h_hi;
        o1_lo = h_lo; o1_hi = h_hi;
        s_alo = r_alo; s_ahi = r_ahi;
        s_placed = r_placed; s_brk = r_brk; s_b = r_b;
        fin_v = 1'b0; fin_lo = r_alo; fin_hi = r_ahi;
        case (r_act)
            ACT_INSERT: begin
                if (({1'b0, h_hi} + XB'(1)) < {1'b0, r_alo}) begin
                    o0v = 1'b1;
                end else if (({1'b0, r_ahi} + XB'(1)) < {1'b0, h_lo}) begin
                    if (!r_placed) begin
                        o0v = 1'b1; o0_lo = r_alo; o0_hi = r_ahi;
                        s_placed = 1'b1;
                    end
                    o1v = 1'b1;
                end else begin
                    if (h_lo < r_alo) s_alo = h_lo;
                    if (h_hi > r_ahi) s_ahi = h_hi;
                end
                fin_v = !r_placed;
            end
            ACT_REMOVE: begin
                if (h_hi < r_lo || h_lo > r_hi) begin
                    o0v = 1'b1;
                end else begin
                    if (h_lo < r_lo) begin
                        o0v = 1'b1; o0_hi = r_lo - CODE_BITS'(1);
                    end
                    if (h_hi > r_hi) begin
                        o1v = 1'b1; o1_lo = r_hi + CODE_BITS'(1);
                    end
                end
            end
            ACT_NEGATE: begin
                if (r_brk || h_lo > r_code_max) begin
                    s_brk = 1'b1;
                end else begin
                    if (r_b < {1'b0, h_lo}) begin
                        o0v = 1'b1; o0_lo = r_b[CODE_BITS-1:0];
                        o0_hi = h_lo - CODE_BITS'(1);
                    end
                    s_b = {1'b0, h_hi} + XB'(1);
                end
                fin_v  = r_b <= {1'b0, r_code_max};
                fin_lo = r_b[CODE_BITS-1:0];
                fin_hi = r_code_max;
            end
            default: ;
        endcase
    end

    // ---- sequencer ----
    logic          out_free, out_load;
    logic          acc;
    logic [NW:0]   total;
    logic          idx_end;

    assign out_free = !r_ovalid || i_ready;
    assign acc      = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign total    = {1'b0, r_new} + (NW+1)'(fin_v);
    assign idx_end  = (r_idx == r_count);

    always_comb begin
        n_state = r_state;
        pop = 1'b0; push = 1'b0;
        bus_lo = h_lo; bus_hi = h_hi;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_action)
                        ACT_INSERT, ACT_REMOVE: begin
                            if (i_low_code > i_high_code || i_high_code > r_code_max)
                                n_state = S_RESP;
                            else
                                n_state = S_DRY;
                        end
                        ACT_NEGATE: n_state = S_DRY;
                        ACT_QUERY:  n_state = S_ROT;
                        ACT_READ:   n_state = (r_count == '0) ? S_RESP : S_ROT;
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_DRY: begin
                if (idx_end) begin
                    n_state = S_CHECK;
                end else begin
                    pop = 1'b1; push = 1'b1;
                end
            end
            S_CHECK: begin
                n_state = (total > (NW+1)'(MAX_RANGES)) ? S_RESP : S_WET;
            end
            S_WET: begin
                if (r_pend) begin
                    push = 1'b1; bus_lo = r_pend_lo; bus_hi = r_pend_hi;
                end else if (!idx_end) begin
                    pop  = 1'b1;
                    push = o0v || o1v;
                    bus_lo = o0v ? o0_lo : o1_lo;
                    bus_hi = o0v ? o0_hi : o1_hi;
                end else begin
                    push = fin_v; bus_lo = fin_lo; bus_hi = fin_hi;
                    n_state = S_RESP;
                end
            end
            S_ROT: begin
                if (idx_end) begin
                    n_state = (r_act == ACT_READ) ? S_IDLE : S_RESP;
                end else if (r_act != ACT_READ || out_free) begin
                    pop = 1'b1; push = 1'b1;
                    out_load = (r_act == ACT_READ);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_max <= CODE_BITS'(1114111);
            r_count    <= '0;
            r_occ      <= '0;
            r_pend     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_code_max_we) r_code_max <= i_code_max;
            r_occ <= r_occ + CW'(push) - CW'(pop);
            if (r_state == S_WET) begin
                if (r_pend) begin
                    r_pend <= 1'b0;
                end else if (!idx_end) begin
                    r_pend <= o0v && o1v;
                end else begin
                    r_count <= total[CW-1:0];
                end
            end
            if (out_load)          r_ovalid <= 1'b1;
            else if (i_ready)      r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_act    <= i_action;
            r_lo     <= i_low_code;
            r_hi     <= i_high_code;
            r_alo    <= i_low_code;
            r_ahi    <= i_high_code;
            r_placed <= 1'b0;
            r_brk    <= 1'b0;
            r_b      <= '0;
            r_idx    <= '0;
            r_new    <= '0;
            r_member <= 1'b0;
            r_status <= ((i_action == ACT_INSERT || i_action == ACT_REMOVE) &&
                         (i_low_code > i_high_code || i_high_code > r_code_max))
                        ? ST_BAD_RANGE : ST_OK;
        end
        if (r_state == S_DRY && !idx_end) begin
            r_alo <= s_alo; r_ahi <= s_ahi;
            r_placed <= s_placed; r_brk <= s_brk; r_b <= s_b;
            r_new <= r_new + NW'(o0v) + NW'(o1v);
            r_idx <= r_idx + CW'(1);
        end
        if (r_state == S_CHECK) begin
            if (total > (NW+1)'(MAX_RANGES)) r_status <= ST_CAPACITY;
            r_alo <= r_lo; r_ahi <= r_hi;
            r_placed <= 1'b0; r_brk <= 1'b0; r_b <= '0;
            r_idx <= '0;
        end
        if (r_state == S_WET && !r_pend && !idx_end) begin
            r_alo <= s_alo; r_ahi <= s_ahi;
            r_placed <= s_placed; r_brk <= s_brk; r_b <= s_b;
            r_pend_lo <= o1_lo; r_pend_hi <= o1_hi;
            r_idx <= r_idx + CW'(1);
        end
        if (r_state == S_ROT && pop) begin
            r_idx <= r_idx + CW'(1);
            if (r_lo >= h_lo && r_lo <= h_hi) r_member <= 1'b1;
        end
        if (out_load) begin
            r_ocount <= r_count;
            if (r_state == S_ROT) begin
                r_omember <= 1'b0;
                r_ostatus <= ST_OK;
                r_olo     <= h_lo;
                r_ohi     <= h_hi;
                r_olast   <= (r_idx == r_count - CW'(1));
            end else begin
                r_omember <= r_member;
                r_ostatus <= r_status;
                r_olo     <= '0;
                r_ohi     <= '0;
                r_olast   <= 1'b1;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_member      = r_omember;
    assign o_status      = r_ostatus;
    assign o_range_low   = r_olo;
    assign o_range_high  = r_ohi;
    assign o_set_empty   = (r_ocount == '0);
    assign o_range_count = COUNT_W'(r_ocount);
    assign o_last        = r_olast;
endmodule
`default_nettype wire
